### rtl/core/edge_min_heap_defines.svh
// ----------------------------------------------------------------------------
// edge_min_heap_defines.svh
// Assertion macros shared by the edge min-heap RTL. They sample on clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EDGE_MIN_HEAP_DEFINES_SVH
`define EDGE_MIN_HEAP_DEFINES_SVH

// check the consequent in the same cycle as the antecedent
`define EMH_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define EMH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/emh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emh_pkg
// Types and constants of the edge min-heap: the stored edge word, the
// operation codes and the sequencer states.
// ----------------------------------------------------------------------------
package emh_pkg;

  // slot numbers and counts are 4 bits wide on every port
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned VTX_W  = 8;
  localparam int unsigned WT_W   = 16;

  // reset value of the entry count register and of the live count
  localparam logic [SLOT_W-1:0] ENTRY_RESET = 4'd8;

  // one stored edge
  typedef struct packed {
    logic [VTX_W-1:0]       va;
    logic [VTX_W-1:0]       vb;
    logic signed [WT_W-1:0] wt;
  } emh_edge_t;

  localparam int unsigned EDGE_W = $bits(emh_edge_t);

  // operation codes
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_BUILD   = 2'd1,
    MODE_EXTRACT = 2'd2
  } emh_mode_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP_RD,
    ST_TOP_CAP,
    ST_BU_NEXT,
    ST_BU_CUR,
    ST_BU_CMP,
    ST_BU_PUT,
    ST_EX_TOP,
    ST_EX_LAST,
    ST_EX_SWAP,
    ST_EX_DOWN,
    ST_EX_LEFT,
    ST_EX_RIGHT,
    ST_EX_CMP,
    ST_EX_PUT,
    ST_DONE
  } emh_state_t;

endpackage

### rtl/core/emh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emh_in_if
// Input channel of the edge min-heap: one operation word per handshake.
// ----------------------------------------------------------------------------
interface emh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         slot;
  logic [7:0]         vertex_a;
  logic [7:0]         vertex_b;
  logic signed [15:0] edge_weight;

  modport source (
    output valid, mode, slot, vertex_a, vertex_b, edge_weight,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, vertex_a, vertex_b, edge_weight,
    output ready
  );
endinterface

### rtl/core/emh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emh_out_if
// Result channel of the edge min-heap: one result word per handshake.
// ----------------------------------------------------------------------------
interface emh_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_vertex_a;
  logic [7:0]         out_vertex_b;
  logic signed [15:0] out_weight;
  logic [3:0]         live_count;
  logic               status;

  modport source (
    output valid, out_vertex_a, out_vertex_b, out_weight, live_count, status,
    input  ready
  );

  modport sink (
    input  valid, out_vertex_a, out_vertex_b, out_weight, live_count, status,
    output ready
  );
endinterface

### rtl/core/emh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module emh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/edge_min_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_min_heap
// Binary min-heap of weighted edges keyed on a signed 16-bit weight, with
// load, build and extract-minimum operations run by a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one operation word at a time and holds in_ch.ready low
// until that word's result has been placed in the output register; a
// finished result may wait there while the next word is taken. Load and the
// unused mode code read the top slot into the result. Extract reads the top
// and the last entry, swaps them and sinks the moved entry one level per
// child compare; extract on an empty heap goes straight to the result.
// Build sifts each slot up in turn, from the first. The pace is set by the
// single read port of the slot RAM (one word per cycle, registered read)
// and by the one signed comparator that decides every sift step.
// Slots are numbered from 1 and slot 1 is the top. The slot field is 4 bits
// wide, so at most min(DEPTH, 15) slots are ever stored. Stored slots read
// as zero until first written, tracked by one valid flag per slot, so no
// clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "edge_min_heap_defines.svh"

module edge_min_heap
  import emh_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  emh_in_if.sink            in_ch,
  emh_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata
);

  // only slots that a 4-bit slot number can reach are stored
  localparam int unsigned SLOTS = (DEPTH < 15) ? DEPTH : 15;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] SLOTS_C = SLOT_W'(SLOTS);

  emh_state_t state_r, state_nxt;

  logic [SLOT_W-1:0] ec_r, ec_nxt;
  logic [SLOT_W-1:0] live_r, live_nxt;
  logic [SLOT_W-1:0] n_r, n_nxt;
  logic [SLOT_W:0]   bk_r, bk_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] cpos_r, cpos_nxt;
  emh_edge_t         cur_r, cur_nxt;
  emh_edge_t         child_r, child_nxt;
  emh_edge_t         res_r, res_nxt;
  logic              status_r, status_nxt;
  logic [SLOTS-1:0]  vld_r, vld_nxt;
  logic              rd_vld_r;

  logic              out_valid_r, out_valid_nxt;
  emh_edge_t         out_edge_r, out_edge_nxt;
  logic [SLOT_W-1:0] out_live_r, out_live_nxt;
  logic              out_status_r, out_status_nxt;

  logic              in_acc;
  logic              out_free;
  logic              slot_ok;
  logic              empty;
  logic [SLOT_W-1:0] n_sel;
  logic [SLOT_W:0]   c_slot;
  logic [SLOT_W:0]   live5;

  logic              we;
  logic [SLOT_W:0]   waddr_slot, raddr_slot;
  logic [SLOT_W:0]   waddr_m1, raddr_m1;
  logic [AW-1:0]     waddr, raddr;
  emh_edge_t         wdata;
  emh_edge_t         ram_q;
  emh_edge_t         rd;

  logic signed [WT_W-1:0] cmp_a, cmp_b;
  logic                   heavier;

  // handshake and decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign slot_ok     = (in_ch.slot != '0) && (in_ch.slot <= SLOTS_C);
  assign empty       = (live_r == '0) || (live_r > SLOTS_C);
  assign n_sel       = (ec_r > SLOTS_C) ? SLOTS_C : ec_r;
  assign c_slot      = {pos_r, 1'b0};
  assign live5       = {1'b0, live_r};

  // slot numbers to RAM addresses
  assign waddr_m1 = waddr_slot - 5'd1;
  assign raddr_m1 = raddr_slot - 5'd1;
  assign waddr    = waddr_m1[AW-1:0];
  assign raddr    = raddr_m1[AW-1:0];

  // slot store
  emh_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // never-written slots read as zero
  assign rd = rd_vld_r ? ram_q : '0;

  // shared weight comparator: operands picked by state
  always_comb begin
    cmp_a = cur_r.wt;
    cmp_b = child_r.wt;
    case (state_r)
      ST_BU_CMP: begin
        cmp_a = rd.wt;
        cmp_b = cur_r.wt;
      end
      ST_EX_RIGHT: begin
        cmp_a = child_r.wt;
        cmp_b = rd.wt;
      end
      default: begin
        cmp_a = cur_r.wt;
        cmp_b = child_r.wt;
      end
    endcase
  end

  assign heavier = cmp_a > cmp_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            MODE_BUILD:   state_nxt = ST_BU_NEXT;
            MODE_EXTRACT: state_nxt = empty ? ST_DONE : ST_EX_TOP;
            default:      state_nxt = ST_TOP_RD;
          endcase
        end
      end
      ST_TOP_RD:   state_nxt = ST_TOP_CAP;
      ST_TOP_CAP:  state_nxt = ST_DONE;
      ST_BU_NEXT:  state_nxt = (bk_r > {1'b0, n_r}) ? ST_TOP_RD : ST_BU_CUR;
      ST_BU_CUR:   state_nxt = (pos_r > 4'd1) ? ST_BU_CMP : ST_BU_NEXT;
      ST_BU_CMP: begin
        if (heavier && (pos_r[3:1] > 3'd1)) begin
          state_nxt = ST_BU_CMP;
        end else begin
          state_nxt = ST_BU_PUT;
        end
      end
      ST_BU_PUT:   state_nxt = ST_BU_NEXT;
      ST_EX_TOP:   state_nxt = ST_EX_LAST;
      ST_EX_LAST:  state_nxt = ST_EX_SWAP;
      ST_EX_SWAP:  state_nxt = ST_EX_DOWN;
      ST_EX_DOWN:  state_nxt = (c_slot > live5) ? ST_EX_PUT : ST_EX_LEFT;
      ST_EX_LEFT:  state_nxt = (c_slot < live5) ? ST_EX_RIGHT : ST_EX_CMP;
      ST_EX_RIGHT: state_nxt = ST_EX_CMP;
      ST_EX_CMP:   state_nxt = heavier ? ST_EX_DOWN : ST_EX_PUT;
      ST_EX_PUT:   state_nxt = ST_DONE;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and store access
  always_comb begin
    ec_nxt         = cfg_we ? cfg_wdata : ec_r;
    live_nxt       = live_r;
    n_nxt          = n_r;
    bk_nxt         = bk_r;
    pos_nxt        = pos_r;
    cpos_nxt       = cpos_r;
    cur_nxt        = cur_r;
    child_nxt      = child_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_edge_nxt   = out_edge_r;
    out_live_nxt   = out_live_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    waddr_slot     = 5'd1;
    wdata          = cur_r;
    raddr_slot     = 5'd1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            MODE_LOAD: begin
              // write the edge; out-of-range slots are dropped
              we         = slot_ok;
              waddr_slot = {1'b0, in_ch.slot};
              wdata.va   = in_ch.vertex_a;
              wdata.vb   = in_ch.vertex_b;
              wdata.wt   = in_ch.edge_weight;
            end
            MODE_BUILD: begin
              n_nxt    = n_sel;
              bk_nxt   = 5'd1;
              live_nxt = n_sel;
            end
            MODE_EXTRACT: begin
              if (empty) begin
                live_nxt   = '0;
                res_nxt    = '0;
                status_nxt = 1'b1;
              end
            end
            default: begin
              live_nxt = live_r;
            end
          endcase
        end
      end
      ST_TOP_CAP: begin
        res_nxt    = rd;
        status_nxt = 1'b0;
      end
      ST_BU_NEXT: begin
        raddr_slot = bk_r;
        pos_nxt    = bk_r[SLOT_W-1:0];
      end
      ST_BU_CUR: begin
        // hold the rising entry, fetch its parent
        cur_nxt    = rd;
        raddr_slot = {2'b00, pos_r[3:1]};
        if (pos_r <= 4'd1) begin
          bk_nxt = bk_r + 5'd1;
        end
      end
      ST_BU_CMP: begin
        // move a heavier parent down, fetch the next parent
        raddr_slot = {3'b000, pos_r[3:2]};
        if (heavier) begin
          we         = 1'b1;
          waddr_slot = {1'b0, pos_r};
          wdata      = rd;
          pos_nxt    = {1'b0, pos_r[3:1]};
        end
      end
      ST_BU_PUT: begin
        we         = 1'b1;
        waddr_slot = {1'b0, pos_r};
        wdata      = cur_r;
        bk_nxt     = bk_r + 5'd1;
      end
      ST_EX_LAST: begin
        res_nxt    = rd;
        status_nxt = 1'b0;
        raddr_slot = live5;
      end
      ST_EX_SWAP: begin
        // old top goes to the last live slot, last entry sinks from the top
        cur_nxt    = rd;
        we         = 1'b1;
        waddr_slot = live5;
        wdata      = res_r;
        live_nxt   = live_r - 4'd1;
        pos_nxt    = 4'd1;
      end
      ST_EX_DOWN: begin
        if (c_slot <= live5) begin
          raddr_slot = c_slot;
        end
      end
      ST_EX_LEFT: begin
        child_nxt = rd;
        cpos_nxt  = c_slot[SLOT_W-1:0];
        if (c_slot < live5) begin
          raddr_slot = c_slot + 5'd1;
        end
      end
      ST_EX_RIGHT: begin
        // left child wins ties
        if (heavier) begin
          child_nxt = rd;
          cpos_nxt  = cpos_r + 4'd1;
        end
      end
      ST_EX_CMP: begin
        if (heavier) begin
          we         = 1'b1;
          waddr_slot = {1'b0, pos_r};
          wdata      = child_r;
          pos_nxt    = cpos_r;
        end
      end
      ST_EX_PUT: begin
        we         = 1'b1;
        waddr_slot = {1'b0, pos_r};
        wdata      = cur_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_edge_nxt   = res_r;
          out_live_nxt   = live_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // mark written slots
  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ec_r        <= ENTRY_RESET;
      live_r      <= ENTRY_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ec_r        <= ec_nxt;
      live_r      <= live_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    bk_r         <= bk_nxt;
    pos_r        <= pos_nxt;
    cpos_r       <= cpos_nxt;
    cur_r        <= cur_nxt;
    child_r      <= child_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    rd_vld_r     <= vld_r[raddr];
    out_edge_r   <= out_edge_nxt;
    out_live_r   <= out_live_nxt;
    out_status_r <= out_status_nxt;
  end

  // result port
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_vertex_a = out_edge_r.va;
  assign out_ch.out_vertex_b = out_edge_r.vb;
  assign out_ch.out_weight   = out_edge_r.wt;
  assign out_ch.live_count   = out_live_r;
  assign out_ch.status       = out_status_r;

  // checks
  `EMH_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ch.ready,
    "sequencer did not leave idle after accepting a word")
  `EMH_ASSERT_NEXT(a_result_posted, (state_r == ST_DONE) && out_free, out_ch.valid,
    "finished result was not posted to the output register")
  `EMH_ASSERT_NOW(a_child_in_range, state_r == ST_EX_CMP,
    (cpos_r <= live_r) && (cpos_r > pos_r),
    "sift-down child slot outside the live heap")
  `EMH_ASSERT_NOW(a_empty_result, out_ch.valid && out_ch.status,
    (out_ch.live_count == '0) && (out_ch.out_weight == '0),
    "empty-heap status with a nonzero count or weight")

endmodule

### sim/edge_min_heap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_min_heap_test
// Self-checking bench for the edge min-heap. Operation words go in over the
// input channel with random gaps. A local heap predictor computes the result
// word for each accepted operation. The result channel is throttled at
// random, and every result word is compared in order against the predicted
// one. Directed tests cover the field extremes, ignored slots, the empty
// heap, ties and an oversized entry count. Random tests then run load, build
// and extract rounds, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module edge_min_heap_test
  import emh_pkg::*;
();

  localparam int unsigned HEAP_SLOTS       = 8;
  localparam logic [1:0]  MODE_UNUSED      = 2'd3;
  localparam int unsigned HEAP_ITEMS       = 1500;
  localparam int unsigned SINK_HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_TAIL       = 40;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int unsigned MAX_REPORTS      = 10;

  // one predicted or observed result word
  typedef struct packed {
    logic [7:0]  va;
    logic [7:0]  vb;
    logic [15:0] wt;
    logic [3:0]  live;
    logic        status;
  } heap_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SLOT_W-1:0] cfg_wdata;

  emh_in_if  op_bus ();
  emh_out_if res_bus ();

  edge_min_heap #(
    .DEPTH (HEAP_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (op_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted heap contents, slot 1 is the top
  emh_edge_t    heap_slots [1:HEAP_SLOTS];
  logic [3:0]   heap_live;
  logic [3:0]   heap_entry_count;
  heap_result_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned heap_items     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  bit          sink_hold_req  = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Narrow weights force ties; wide ones sweep every bit.
  function automatic logic [15:0] rand_weight(input bit narrow);
    int w;
    if (narrow)
      w = int'($urandom_range(0, 6)) - 3;
    else
      w = int'($urandom_range(0, 65535));
    return w[15:0];
  endfunction

  function automatic bit slot_heavier(input int x, input int y);
    return $signed(heap_slots[x].wt) > $signed(heap_slots[y].wt);
  endfunction

  function automatic void swap_slots(input int x, input int y);
    emh_edge_t t;
    t = heap_slots[x];
    heap_slots[x] = heap_slots[y];
    heap_slots[y] = t;
  endfunction

  function automatic void sift_up(input int k);
    while (k > 1 && slot_heavier(k / 2, k)) begin
      swap_slots(k / 2, k);
      k = k / 2;
    end
  endfunction

  // Sink slot 1 over live slots 1..n; the left child wins ties.
  function automatic void sift_down(input int n);
    int k;
    int c;
    k = 1;
    while (2 * k <= n) begin
      c = 2 * k;
      if (c < n && slot_heavier(c, c + 1))
        c++;
      if (!slot_heavier(k, c))
        break;
      swap_slots(k, c);
      k = c;
    end
  endfunction

  // Apply one accepted word to the predicted heap and queue its result.
  function automatic void predict_heap_step(input logic [1:0] mode, input logic [3:0] slot,
                                            input logic [7:0] va, input logic [7:0] vb,
                                            input logic [15:0] wt);
    emh_edge_t top;
    int        n;
    case (mode)
      MODE_LOAD: begin
        if (slot >= 1 && slot <= HEAP_SLOTS)
          heap_slots[slot] = '{va, vb, wt};
      end
      MODE_BUILD: begin
        n = (heap_entry_count > HEAP_SLOTS) ? int'(HEAP_SLOTS) : int'(heap_entry_count);
        for (int k = 1; k <= n; k++)
          sift_up(k);
        heap_live = n[3:0];
      end
      MODE_EXTRACT: begin
        if (heap_live == 0) begin
          pending_results.push_back('{8'd0, 8'd0, 16'd0, 4'd0, 1'b1});
          return;
        end
        top = heap_slots[1];
        n = int'(heap_live);
        swap_slots(1, n);
        heap_live = heap_live - 4'd1;
        sift_down(n - 1);
        pending_results.push_back('{top.va, top.vb, top.wt, heap_live, 1'b0});
        return;
      end
      default: ;
    endcase
    pending_results.push_back('{heap_slots[1].va, heap_slots[1].vb, heap_slots[1].wt,
                                heap_live, 1'b0});
  endfunction

  // Offer one word; entered and left at a falling edge.
  task automatic send_word(input logic [1:0] mode, input logic [3:0] slot,
                           input logic [7:0] va, input logic [7:0] vb,
                           input logic [15:0] wt);
    int unsigned gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = pick_gap();
      op_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_bus.valid       <= 1'b1;
    op_bus.mode        <= mode;
    op_bus.slot        <= slot;
    op_bus.vertex_a    <= va;
    op_bus.vertex_b    <= vb;
    op_bus.edge_weight <= wt;
    do @(posedge clk); while (!op_bus.ready);
    predict_heap_step(mode, slot, va, vb, wt);
    @(negedge clk);
  endtask

  // Stop offering and hold until every predicted word has come back.
  task automatic wait_results_drained();
    op_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_entry_count(input logic [3:0] value);
    wait_results_drained();
    repeat (2) @(negedge clk);
    cfg_we           <= 1'b1;
    cfg_wdata        <= value;
    heap_entry_count = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Load a slot outside 1..8 or send the unused mode code.
  task automatic send_noise();
    logic [3:0] bad_slot;
    bad_slot = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    if ($urandom_range(0, 1) == 0)
      send_word(MODE_LOAD, bad_slot, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), rand_weight(1'b0));
    else
      send_word(MODE_UNUSED, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), rand_weight(1'b0));
  endtask

  task automatic test_after_reset();
    // all-zero heap with eight live entries
    send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_UNUSED, 4'hF, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_field_extremes();
    send_word(MODE_LOAD, 4'd1, 8'hFF, 8'h00, 16'h8000);
    send_word(MODE_LOAD, 4'd8, 8'h00, 8'hFF, 16'h7FFF);
    send_word(MODE_LOAD, 4'd2, 8'hAA, 8'h55, 16'hFFFF);
    // out-of-range slots leave the store alone
    send_word(MODE_LOAD, 4'd0, 8'h11, 8'h22, 16'h0001);
    send_word(MODE_LOAD, 4'd9, 8'h33, 8'h44, 16'h0002);
    send_word(MODE_LOAD, 4'd15, 8'h55, 8'h66, 16'h0003);
    // entry count above the depth builds all eight slots
    set_entry_count(4'd15);
    send_word(MODE_BUILD, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic test_empty_heap();
    set_entry_count(4'd0);
    send_word(MODE_BUILD, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_UNUSED, 4'd0, 8'h00, 8'h00, 16'h0000);
    send_word(MODE_LOAD, 4'd3, 8'h12, 8'h34, 16'h0042);
    send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic test_equal_weights();
    set_entry_count(4'd3);
    send_word(MODE_LOAD, 4'd1, 8'd1, 8'd10, 16'sd5);
    send_word(MODE_LOAD, 4'd2, 8'd2, 8'd20, 16'sd5);
    send_word(MODE_LOAD, 4'd3, 8'd3, 8'd30, 16'sd5);
    send_word(MODE_BUILD, 4'd0, 8'h00, 8'h00, 16'h0000);
    repeat (4) send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
  endtask

  // Hold the result side off while words keep coming, then drain.
  task automatic test_output_holdoff();
    set_entry_count(4'd8);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    sink_hold_req  = 1'b1;
    for (int k = 1; k <= HEAP_SLOTS; k++)
      send_word(MODE_LOAD, k[3:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                rand_weight(1'b0));
    send_word(MODE_BUILD, 4'd0, 8'h00, 8'h00, 16'h0000);
    repeat (3) send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
    wait_results_drained();
  endtask

  // Rounds of load, build and extract with random content and pacing.
  task automatic test_random_heaps();
    int unsigned n;
    int unsigned filled;
    int unsigned extracts;
    bit          narrow;
    while (heap_items < HEAP_ITEMS) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      set_entry_count(n[3:0]);
      filled = (n > HEAP_SLOTS) ? HEAP_SLOTS : n;
      case ($urandom_range(0, 3))
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 30;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 30;
        end
        default: begin
          send_idle_pct  = 50;
          sink_stall_pct = 50;
        end
      endcase
      narrow = 1'($urandom_range(0, 1));
      for (int k = 1; k <= filled; k++) begin
        send_word(MODE_LOAD, k[3:0], 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), rand_weight(narrow));
        heap_items++;
        if ($urandom_range(0, 15) == 0)
          send_noise();
      end
      send_word(MODE_BUILD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), rand_weight(1'b0));
      heap_items++;
      extracts = filled + $urandom_range(0, 2);
      for (int k = 0; k < extracts; k++) begin
        // overwrite a slot in mid-drain now and then
        if ($urandom_range(0, 9) == 0) begin
          send_word(MODE_LOAD, 4'($urandom_range(1, HEAP_SLOTS)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), rand_weight(narrow));
          heap_items++;
        end
        send_word(MODE_EXTRACT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), rand_weight(1'b0));
        heap_items++;
      end
      // rebuild over what is left in the store
      if ($urandom_range(0, 5) == 0) begin
        send_word(MODE_BUILD, 4'd0, 8'h00, 8'h00, 16'h0000);
        repeat (2) send_word(MODE_EXTRACT, 4'd0, 8'h00, 8'h00, 16'h0000);
        heap_items += 3;
      end
    end
  endtask

  // Result-side pacing: random stalls, plus one long hold on request.
  initial begin : result_pacing
    int unsigned gap;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        gap = pick_gap();
        res_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    heap_result_t got;
    heap_result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.out_vertex_a, res_bus.out_vertex_b, res_bus.out_weight,
              res_bus.live_count, res_bus.status};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with none expected: a=%0d b=%0d w=%0d live=%0d st=%0d",
                   $realtime, got.va, got.vb, $signed(got.wt), got.live, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected a=%0d b=%0d w=%0d live=%0d st=%0d, got a=%0d b=%0d w=%0d live=%0d st=%0d",
                     $realtime, want.va, want.vb, $signed(want.wt), want.live, want.status,
                     got.va, got.vb, $signed(got.wt), got.live, got.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("edge_min_heap verification failed");
      $finish;
    end
  end

  initial begin : run_all
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    op_bus.valid       = 1'b0;
    op_bus.mode        = MODE_LOAD;
    op_bus.slot        = '0;
    op_bus.vertex_a    = '0;
    op_bus.vertex_b    = '0;
    op_bus.edge_weight = '0;
    for (int k = 1; k <= HEAP_SLOTS; k++)
      heap_slots[k] = '0;
    heap_live        = ENTRY_RESET;
    heap_entry_count = ENTRY_RESET;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_field_extremes();
    test_empty_heap();
    test_equal_weights();
    test_output_holdoff();
    test_random_heaps();

    wait_results_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("edge_min_heap verification clean");
    else
      $display("edge_min_heap verification failed");
    $finish;
  end

endmodule
